// File: hw/rtl/text_line_annotator_defines.svh
// Assertion macros shared by the RTL files of the line annotator.
`ifndef TEXT_LINE_ANNOTATOR_DEFINES_SVH
`define TEXT_LINE_ANNOTATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TLA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define TLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define TLA_ASSERT(lbl, clk, rst_n, prop)
`define TLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/tla_pkg.sv
package tla_pkg;

  localparam int NUM_DIGITS  = 6;
  localparam int CNT_W       = 4 * NUM_DIGITS;
  localparam int PH_N        = NUM_DIGITS + 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER_MODE = 3'd0,
    REG_SQUEEZE     = 3'd1,
    REG_ENDS        = 3'd2,
    REG_TABS        = 3'd3,
    REG_NONPRINT    = 3'd4
  } reg_index_t;

  localparam logic [1:0] MODE_ALL      = 2'd1;
  localparam logic [1:0] MODE_NONBLANK = 2'd2;

  typedef enum logic [1:0] {
    CLASS_START    = 2'd0,
    CLASS_AFTER_NL = 2'd1,
    CLASS_MID      = 2'd2
  } class_t;

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_QMARK    = 8'd63;
  localparam logic [7:0] CH_I        = 8'd73;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_en;
    logic       ends_en;
    logic       tabs_en;
    logic       nonprint_en;
  } cfg_t;

  // One queue entry: everything the back end needs to emit the bytes of one input byte.
  typedef struct packed {
    logic                  sep;
    logic                  num;
    logic [CNT_W-1:0]      count;
    logic [NUM_DIGITS-1:0] lead;
    logic [1:0]            tail_cnt;
    logic [7:0]            tail0;
    logic [7:0]            tail1;
  } cmd_t;

  function automatic logic [CNT_W-1:0] bcd_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    logic             carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] >= 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tla_queue.sv
`include "text_line_annotator_defines.svh"

module tla_queue import tla_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic head_valid
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  `TLA_ASSERT(a_count_bound, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH))
  `TLA_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full || pop)
  `TLA_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)

endmodule

// File: hw/rtl/tla_front.sv
module tla_front import tla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  class_t           prev_class_r;
  class_t           prev_class_nxt;
  logic             blank_run_r;
  logic             blank_run_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             file_seen_r;

  logic   accept;
  logic   eff_first;
  class_t pc;
  logic   br;
  logic   at_start;
  logic   is_nl;
  logic   squeezed;
  logic   is_ctrl;
  logic   zero_run;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    eff_first = in_tuser || !file_seen_r;
    pc        = eff_first ? CLASS_START : prev_class_r;
    br        = eff_first ? 1'b0 : blank_run_r;
    at_start  = (pc != CLASS_MID);
    is_nl     = (in_tdata == CH_NL);
    squeezed  = is_nl && at_start && cfg.squeeze_en && br;
    is_ctrl   = ((in_tdata < CH_SPACE) && (in_tdata != CH_TAB)) || (in_tdata == CH_DEL);

    push_cmd.sep   = in_tuser && file_seen_r;
    push_cmd.num   = !squeezed && at_start &&
                     ((cfg.number_mode == MODE_ALL) ||
                      ((cfg.number_mode == MODE_NONBLANK) && !is_nl));
    push_cmd.count = count_r;

    zero_run = 1'b1;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      zero_run         = zero_run && (count_r[4*i +: 4] == 4'd0);
      push_cmd.lead[i] = zero_run && (i != 0);
    end

    push_cmd.tail_cnt = 2'd1;
    push_cmd.tail0    = in_tdata;
    push_cmd.tail1    = CH_NL;
    priority if (squeezed) begin
      push_cmd.tail_cnt = 2'd0;
    end else if (is_nl) begin
      if (cfg.ends_en) begin
        push_cmd.tail_cnt = 2'd2;
        push_cmd.tail0    = CH_DOLLAR;
      end
    end else if ((in_tdata == CH_TAB) && cfg.tabs_en) begin
      push_cmd.tail_cnt = 2'd2;
      push_cmd.tail0    = CH_CARET;
      push_cmd.tail1    = CH_I;
    end else if (cfg.nonprint_en && is_ctrl) begin
      push_cmd.tail_cnt = 2'd2;
      push_cmd.tail0    = CH_CARET;
      push_cmd.tail1    = (in_tdata == CH_DEL) ? CH_QMARK : (in_tdata + CTRL_OFFSET);
    end else begin
      push_cmd.tail_cnt = 2'd1;
    end

    push = accept && (push_cmd.sep || !squeezed);

    prev_class_nxt = pc;
    blank_run_nxt  = br;
    if (!squeezed) begin
      if (is_nl) begin
        prev_class_nxt = CLASS_AFTER_NL;
        blank_run_nxt  = at_start;
      end else begin
        prev_class_nxt = CLASS_MID;
        blank_run_nxt  = 1'b0;
      end
    end
    count_nxt = push_cmd.num ? bcd_inc(count_r) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_class_r <= CLASS_START;
      blank_run_r  <= 1'b0;
      count_r      <= CNT_W'(1);
      file_seen_r  <= 1'b0;
    end else if (accept) begin
      prev_class_r <= prev_class_nxt;
      blank_run_r  <= blank_run_nxt;
      count_r      <= count_nxt;
      file_seen_r  <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/tla_back.sv
`include "text_line_annotator_defines.svh"

module tla_back import tla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [PH_N-1:0] done_r;
  logic [PH_N-1:0] done_nxt;
  logic            out_tvalid_r;
  logic [7:0]      out_tdata_r;
  logic            out_tlast_r;

  logic [PH_N-1:0] pres;
  logic [PH_N-1:0] remaining;
  logic [PH_N-1:0] cur;
  logic            last;
  logic            emit;
  logic [7:0]      byte_sel;

  // Phases: separator, the digits from the top down, tab, then up to two text bytes.
  always_comb begin
    pres[0] = head.sep;
    for (int j = 1; j <= NUM_DIGITS; j++) begin
      pres[j] = head.num;
    end
    pres[NUM_DIGITS+1] = head.num;
    pres[NUM_DIGITS+2] = (head.tail_cnt != 2'd0);
    pres[NUM_DIGITS+3] = (head.tail_cnt == 2'd2);

    remaining = pres & ~done_r;
    cur       = remaining & (~remaining + PH_N'(1));
    last      = ((remaining & ~cur) == '0);
    emit      = head_valid && (!out_tvalid_r || out_tready);
    pop       = emit && last;

    byte_sel = '0;
    if (cur[0]) begin
      byte_sel = byte_sel | CH_NL;
    end
    for (int j = 1; j <= NUM_DIGITS; j++) begin
      if (cur[j]) begin
        byte_sel = byte_sel | (head.lead[NUM_DIGITS-j] ? CH_SPACE :
                   (CH_ZERO | {4'd0, head.count[4*(NUM_DIGITS-j) +: 4]}));
      end
    end
    if (cur[NUM_DIGITS+1]) begin
      byte_sel = byte_sel | CH_TAB;
    end
    if (cur[NUM_DIGITS+2]) begin
      byte_sel = byte_sel | head.tail0;
    end
    if (cur[NUM_DIGITS+3]) begin
      byte_sel = byte_sel | head.tail1;
    end

    done_nxt = done_r;
    if (emit) begin
      done_nxt = last ? '0 : (done_r | cur);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= byte_sel;
      out_tlast_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `TLA_ASSERT_IMPL(a_one_phase, clk, rst_n, emit, $onehot(cur))
  `TLA_ASSERT_IMPL(a_done_clear_idle, clk, rst_n, !head_valid, done_r == '0)

endmodule

// File: hw/rtl/text_line_annotator.sv
// Cat-style text annotator. Each input transaction carries one byte of a file; the block
// emits that byte, possibly decorated, as one or more output transactions, the last of which
// has out_tlast set. Depending on the configuration it puts a separator newline between
// files, a six-digit right-justified line number and a tab before each line (or each
// nonblank line), squeezes runs of blank lines, shows '$' before newlines, ^I for tabs and
// ^X or ^? for control bytes. The front end classifies a byte combinationally and queues a
// command, so input is taken every cycle while the four-entry command queue has room. The
// back end emits one output byte per cycle while the output is not stalled; an input byte yields up
// to ten output bytes (ten when it opens a file and a numbered line with a two-byte tail); throughput is set
// by the number of output bytes produced. Squeezed blank lines produce no output transaction.
// The line counter runs on across files and wraps to zero after 999999. in_tlast is taken
// with the byte but has no effect on the output. Configuration may be written only while no
// transaction is in flight. Reset needs no clearing pass.
module text_line_annotator import tla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // in_byte
  input  logic                  in_tuser,   // file_first
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // out_byte
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t head;
  logic head_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_NUMBER_MODE: cfg_nxt.number_mode = cfg_wdata;
        REG_SQUEEZE:     cfg_nxt.squeeze_en  = cfg_wdata[0];
        REG_ENDS:        cfg_nxt.ends_en     = cfg_wdata[0];
        REG_TABS:        cfg_nxt.tabs_en     = cfg_wdata[0];
        REG_NONPRINT:    cfg_nxt.nonprint_en = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tla_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  tla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/text_line_annotator_tb.sv
`timescale 1ns / 100ps

module text_line_annotator_tb import tla_pkg::*;;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 48;
  localparam int NUM_PHASES    = 8;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  class annotated_stream;
    beat_t            awaited[$];
    cfg_t             regs;
    class_t           line_pos;
    logic             blank_seen;
    logic [CNT_W-1:0] line_no;
    logic             any_taken;
    int               errors;

    function new();
      regs       = '0;
      line_pos   = CLASS_START;
      blank_seen = 1'b0;
      line_no    = CNT_W'(1);
      any_taken  = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_NUMBER_MODE: regs.number_mode = v;
        REG_SQUEEZE:     regs.squeeze_en  = v[0];
        REG_ENDS:        regs.ends_en     = v[0];
        REG_TABS:        regs.tabs_en     = v[0];
        REG_NONPRINT:    regs.nonprint_en = v[0];
        default: ;
      endcase
    endfunction

    // Works out the bytes that one accepted input byte should produce.
    function void take_byte(logic [7:0] c, logic first);
      logic [7:0] b[$];
      logic       lead;
      logic       at_start;
      logic       carry;
      logic [3:0] d;
      if (first) begin
        if (any_taken) b.push_back(CH_NL);
        line_pos   = CLASS_START;
        blank_seen = 1'b0;
      end
      any_taken = 1'b1;
      at_start  = (line_pos != CLASS_MID);
      if (!(c == CH_NL && at_start && regs.squeeze_en && blank_seen)) begin
        if (at_start && (regs.number_mode == MODE_ALL ||
                         (regs.number_mode == MODE_NONBLANK && c != CH_NL))) begin
          lead = 1'b1;
          for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            d = line_no[4*i +: 4];
            if (d != 4'd0 || i == 0) lead = 1'b0;
            b.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
          end
          b.push_back(CH_TAB);
          carry = 1'b1;
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (carry) begin
              if (line_no[4*i +: 4] == 4'd9) begin
                line_no[4*i +: 4] = 4'd0;
              end else begin
                line_no[4*i +: 4] = line_no[4*i +: 4] + 4'd1;
                carry = 1'b0;
              end
            end
          end
        end
        if (c == CH_NL) begin
          if (regs.ends_en) b.push_back(CH_DOLLAR);
          b.push_back(CH_NL);
          blank_seen = at_start;
          line_pos   = CLASS_AFTER_NL;
        end else begin
          blank_seen = 1'b0;
          line_pos   = CLASS_MID;
          if (c == CH_TAB && regs.tabs_en) begin
            b.push_back(CH_CARET);
            b.push_back(CH_I);
          end else if (regs.nonprint_en && ((c < CH_SPACE && c != CH_TAB) || c == CH_DEL)) begin
            b.push_back(CH_CARET);
            b.push_back(c == CH_DEL ? CH_QMARK : c + CTRL_OFFSET);
          end else begin
            b.push_back(c);
          end
        end
      end
      foreach (b[k]) awaited.push_back(beat_t'{b[k], (k == b.size() - 1)});
    endfunction

    function void match_byte(logic [7:0] data, logic last);
      beat_t w;
      if (awaited.size() == 0) begin
        $error("unexpected output transaction: out_byte %0h, run_end %0b", data, last);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (data !== w.data) begin
        $error("out_byte: expected %0h, actual %0h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("run_end: expected %0b, actual %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // in_byte
  logic                  in_tuser;   // file_first
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // out_byte
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  annotated_stream ann = new();
  int burst_left;
  int gap_max;
  int phase_items;
  bit hold_req;

  text_line_annotator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Input and output transactions are both taken here, so that a prediction is always in place
  // before a result of the same edge is compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) ann.take_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) ann.match_byte(out_tdata, out_tlast);
    end
  end

  initial begin : receiver
    int style;
    int left;
    out_tready = 1'b0;
    style      = 0;
    left       = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left  = $urandom_range(16, 96);
        end
        left--;
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic first, logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    phase_items++;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every predicted byte has come out, then lets a squeezed line clear the block.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (ann.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    ann.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(logic [1:0] mode, logic sq, logic en, logic tb, logic np);
    settle();
    write_reg(REG_NUMBER_MODE, mode);
    write_reg(REG_SQUEEZE, {1'b0, sq});
    write_reg(REG_ENDS, {1'b0, en});
    write_reg(REG_TABS, {1'b0, tb});
    write_reg(REG_NONPRINT, {1'b0, np});
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) return CH_NL;
    if (r < 42) return CH_TAB;
    if (r < 52) return 8'($urandom_range(0, 31));
    if (r < 57) return CH_DEL;
    if (r < 67) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // A file of random text; now and then its first or last marks are broken.
  task automatic send_file();
    int  len;
    bit  broken;
    logic first;
    logic last;
    len    = $urandom_range(1, 24);
    broken = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      first = (k == 0) && !(broken && $urandom_range(0, 1) == 1);
      last  = broken ? logic'($urandom_range(0, 1)) : (k == len - 1);
      send_item(pick_byte(), first, last);
    end
  endtask

  initial begin : stimulus
    logic [1:0] mode;
    logic [3:0] flags;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    burst_left = 0;
    gap_max    = 3;
    hold_req   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_config(MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
    write_reg(REG_SPARE, 2'd3);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(CH_TAB, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h1F, 1'b0, 1'b0);
    send_item(CH_DEL, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(CH_NL, 1'b0, 1'b0);
    send_item(CH_NL, 1'b0, 1'b0);
    send_item(CH_NL, 1'b0, 1'b0);
    send_item(CH_NL, 1'b0, 1'b1);
    send_item(CH_NL, 1'b1, 1'b0);
    send_item(CH_NL, 1'b1, 1'b1);
    send_item(CH_SPACE, 1'b1, 1'b0);
    send_item(8'h7E, 1'b0, 1'b1);

    apply_config(MODE_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(CH_NL, 1'b1, 1'b0);
    send_item(8'h78, 1'b0, 1'b0);
    send_item(CH_TAB, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(CH_DEL, 1'b0, 1'b0);
    send_item(CH_NL, 1'b0, 1'b0);
    send_item(CH_NL, 1'b0, 1'b0);
    send_item(8'h41, 1'b0, 1'b1);

    apply_config(MODE_UNUSED, 1'b0, 1'b1, 1'b0, 1'b1);
    send_item(CH_TAB, 1'b1, 1'b0);
    send_item(CH_NL, 1'b0, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin mode = MODE_NONE;     flags = 4'b0000; end
        1: begin mode = MODE_ALL;      flags = 4'b1111; end
        2: begin mode = MODE_NONBLANK; flags = 4'b1111; end
        3: begin mode = MODE_UNUSED;   flags = 4'b1010; end
        default: begin
          mode  = 2'($urandom_range(0, 3));
          flags = 4'($urandom_range(0, 15));
        end
      endcase
      apply_config(mode, flags[3], flags[2], flags[1], flags[0]);
      gap_max     = (ph == 4) ? 0 : 8;
      phase_items = 0;
      if (ph == 1) hold_req = 1'b1;
      while (phase_items < PHASE_ITEMS) send_file();
    end

    settle();
    if (ann.errors == 0 && ann.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
